// ===== hw/rtl/rgmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rgmt_pkg
// Shared request codes, status codes and the controller/datapath bundles of
// the robot group membership table.
// ----------------------------------------------------------------------------
package rgmt_pkg;

    typedef enum logic [1:0] {
        REQ_JOIN    = 2'd0,
        REQ_LEAVE   = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_REFRESH = 2'd3
    } req_type_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_LIST_FULL  = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic pick;
        logic prep_srch;
        logic srch;
        logic prep_shift;
        logic shift;
        logic upd;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic      clr_last;
        logic      scan_done;
        logic      hit;
        logic      pk_ent;
        logic      srch_done;
        logic      found;
        logic      shift_done;
        logic      upd_ent;
        logic      out_free;
        req_type_t req_type;
        logic      first;
        logic      empty;
    } dp_sts_t;

endpackage

// ===== hw/rtl/rgmt_if.sv =====
// ----------------------------------------------------------------------------
// rgmt_req_if / rgmt_rsp_if
// Valid/ready channels for membership requests and their results.
// ----------------------------------------------------------------------------
interface rgmt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] robot_id;
    logic [15:0] group_id;
    logic        first_of_run;
    logic        run_empty;

    modport source (
        output valid, req_type, robot_id, group_id, first_of_run, run_empty,
        input  ready
    );
    modport sink (
        input  valid, req_type, robot_id, group_id, first_of_run, run_empty,
        output ready
    );
endinterface

interface rgmt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       is_member;
    logic       entry_present;
    logic [3:0] group_count;

    modport source (
        output valid, status, is_member, entry_present, group_count,
        input  ready
    );
    modport sink (
        input  valid, status, is_member, entry_present, group_count,
        output ready
    );
endinterface

// ===== hw/rtl/robot_group_membership_table.sv =====
// ----------------------------------------------------------------------------
// robot_group_membership_table
// Per-robot group lists: join, leave, query and list refresh requests.
//
// Channels: req (valid/ready) carries one request per transfer; rsp
// (valid/ready) returns exactly one result per request, in order.
// After reset the slot table is cleared, one slot per cycle; req.ready
// stays low during that pass.
// One request is processed at a time. A request runs a slot scan (one
// slot per cycle through the slot memory's read port, stopping at the first
// match), then the list search, shift and update that its type needs,
// through the single read port of the group memory.
// The result sits in an output register; req.ready returns as soon as the
// result is loaded, so the next request proceeds while rsp is stalled and
// only waits at its own result hand-off.
// ----------------------------------------------------------------------------
module robot_group_membership_table #(
    parameter int ROBOT_ENTRIES    = 64,
    parameter int GROUPS_PER_ROBOT = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    rgmt_req_if.sink   req,
    rgmt_rsp_if.source rsp
);

    rgmt_pkg::dp_cmd_t cmd;
    rgmt_pkg::dp_sts_t sts;

    rgmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rgmt_datapath #(
        .ROBOT_ENTRIES    (ROBOT_ENTRIES),
        .GROUPS_PER_ROBOT (GROUPS_PER_ROBOT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req.req_type),
        .robot_id      (req.robot_id),
        .group_id      (req.group_id),
        .first_of_run  (req.first_of_run),
        .run_empty     (req.run_empty),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .status        (rsp.status),
        .is_member     (rsp.is_member),
        .entry_present (rsp.entry_present),
        .group_count   (rsp.group_count)
    );

endmodule

// ===== hw/rtl/rgmt_datapath.sv =====
// ----------------------------------------------------------------------------
// rgmt_datapath
// Slot table and group list memories, scan and list sweep counters,
// update logic and the result register.
// ----------------------------------------------------------------------------
module rgmt_datapath #(
    parameter int ROBOT_ENTRIES    = 64,
    parameter int GROUPS_PER_ROBOT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rgmt_pkg::dp_cmd_t cmd,
    output rgmt_pkg::dp_sts_t sts,
    input  logic [1:0]        req_type,
    input  logic [15:0]       robot_id,
    input  logic [15:0]       group_id,
    input  logic              first_of_run,
    input  logic              run_empty,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [1:0]        status,
    output logic              is_member,
    output logic              entry_present,
    output logic [3:0]        group_count
);

    localparam int SW  = $clog2(ROBOT_ENTRIES);
    localparam int SCW = $clog2(ROBOT_ENTRIES + 1);
    localparam int CW  = $clog2(GROUPS_PER_ROBOT + 1);
    localparam int GAW = $clog2(ROBOT_ENTRIES * GROUPS_PER_ROBOT);
    localparam int RW  = 17 + CW;

    localparam logic [SCW-1:0] N_S    = SCW'(ROBOT_ENTRIES);
    localparam logic [SCW-1:0] NLAST  = SCW'(ROBOT_ENTRIES - 1);
    localparam logic [CW-1:0]  G_C    = CW'(GROUPS_PER_ROBOT);
    localparam logic [GAW-1:0] G_A    = GAW'(GROUPS_PER_ROBOT);

    // slot record: {valid, robot, count}
    logic [RW-1:0]  slot_mem [ROBOT_ENTRIES];
    logic [15:0]    grp_mem  [ROBOT_ENTRIES * GROUPS_PER_ROBOT];

    rgmt_pkg::req_type_t req_type_reg;
    logic [15:0]    robot_reg;
    logic [15:0]    group_reg;
    logic           first_reg;
    logic           empty_reg;

    logic [SCW-1:0] sidx_reg;
    logic           schk_vld_reg;
    logic [SW-1:0]  schk_idx_reg;
    logic [RW-1:0]  slot_rd_reg;
    logic           hit_reg;
    logic [SW-1:0]  hslot_reg;
    logic [CW-1:0]  hcnt_reg;
    logic           free_reg;
    logic [SW-1:0]  fslot_reg;

    logic [SW-1:0]  slot_reg;
    logic [CW-1:0]  cnt_reg;
    logic           ent_reg;
    logic [GAW-1:0] base_reg;
    logic [1:0]     status_reg;

    logic [CW-1:0]  gidx_reg;
    logic           gchk_vld_reg;
    logic [CW-1:0]  gchk_idx_reg;
    logic [15:0]    grp_rd_reg;
    logic           found_reg;
    logic [CW-1:0]  fidx_reg;
    logic           removed_reg;

    logic           out_vld_reg;
    logic [1:0]     out_status_reg;
    logic           out_member_reg;
    logic           out_present_reg;
    logic [3:0]     out_count_reg;

    logic           rd_vld;
    logic [15:0]    rd_rob;
    logic [CW-1:0]  rd_cnt;
    logic           s_issue;
    logic           g_issue;
    logic           is_join;
    logic           is_leave;
    logic           is_ref;
    logic           need_alloc;
    logic           pk_ent;
    logic [SW-1:0]  slot_sel;
    logic [CW-1:0]  cnt_eff;
    logic           do_app;
    logic           app_full;
    logic           app_ok;
    logic [CW-1:0]  upd_cnt;
    logic           upd_vld;
    logic           slot_we;
    logic [SW-1:0]  slot_waddr;
    logic [RW-1:0]  slot_wdata;
    logic           grp_we;
    logic [GAW-1:0] grp_waddr;
    logic [15:0]    grp_wdata;
    logic [GAW-1:0] grp_raddr;
    logic [CW+3:0]  cnt_ext;

    assign rd_vld = slot_rd_reg[RW-1];
    assign rd_rob = slot_rd_reg[CW +: 16];
    assign rd_cnt = slot_rd_reg[CW-1:0];

    assign is_join  = (req_type_reg == rgmt_pkg::REQ_JOIN);
    assign is_leave = (req_type_reg == rgmt_pkg::REQ_LEAVE);
    assign is_ref   = (req_type_reg == rgmt_pkg::REQ_REFRESH);

    assign s_issue = cmd.scan && (sidx_reg < N_S);
    assign g_issue = (cmd.srch || cmd.shift) && (gidx_reg < cnt_reg);

    assign need_alloc = is_join || (is_ref && (first_reg || !empty_reg));
    assign pk_ent     = hit_reg || (need_alloc && free_reg);
    assign slot_sel   = hit_reg ? hslot_reg : fslot_reg;

    assign cnt_eff  = (is_ref && first_reg) ? '0 : cnt_reg;
    assign do_app   = is_join || (is_ref && !empty_reg);
    assign app_full = (cnt_eff >= G_C);
    assign app_ok   = do_app && !app_full;

    always_comb
    begin
        if (app_ok)
        begin
            upd_cnt = cnt_eff + CW'(1);
        end
        else if (is_leave && removed_reg)
        begin
            upd_cnt = cnt_reg - CW'(1);
        end
        else
        begin
            upd_cnt = cnt_eff;
        end
    end

    assign upd_vld = !(is_leave && (upd_cnt == '0));

    // slot memory port
    assign slot_we    = cmd.clr || cmd.upd;
    assign slot_waddr = cmd.clr ? sidx_reg[SW-1:0] : slot_reg;
    assign slot_wdata = cmd.clr ? '0 : {upd_vld, robot_reg, upd_cnt};

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[sidx_reg[SW-1:0]];
    end

    // group list memory port
    assign grp_raddr = base_reg + GAW'(gidx_reg);
    assign grp_we    = (cmd.upd && app_ok) || (cmd.shift && gchk_vld_reg);
    assign grp_waddr = cmd.upd ? (base_reg + GAW'(cnt_eff))
                               : (base_reg + GAW'(gchk_idx_reg) - GAW'(1));
    assign grp_wdata = cmd.upd ? group_reg : grp_rd_reg;

    always_ff @(posedge clk)
    begin
        if (grp_we)
        begin
            grp_mem[grp_waddr] <= grp_wdata;
        end
        grp_rd_reg <= grp_mem[grp_raddr];
    end

    // request fields and per-item payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= rgmt_pkg::req_type_t'(req_type);
            robot_reg    <= robot_id;
            group_reg    <= group_id;
            first_reg    <= first_of_run;
            empty_reg    <= run_empty;
        end
        schk_idx_reg <= sidx_reg[SW-1:0];
        gchk_idx_reg <= gidx_reg;
        if (cmd.scan && schk_vld_reg)
        begin
            if (rd_vld && (rd_rob == robot_reg) && !hit_reg)
            begin
                hslot_reg <= schk_idx_reg;
                hcnt_reg  <= rd_cnt;
            end
            if (!rd_vld && !free_reg)
            begin
                fslot_reg <= schk_idx_reg;
            end
        end
        if (cmd.pick)
        begin
            slot_reg <= slot_sel;
            base_reg <= GAW'(slot_sel) * G_A;
        end
        if (cmd.srch && gchk_vld_reg && !found_reg && (grp_rd_reg == group_reg))
        begin
            fidx_reg <= gchk_idx_reg;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= status_reg;
            out_member_reg  <= ent_reg && found_reg;
            out_present_reg <= ent_reg;
            out_count_reg   <= ent_reg ? cnt_ext[3:0] : 4'd0;
        end
    end

    assign cnt_ext = {4'd0, cnt_reg};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sidx_reg     <= '0;
            schk_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            cnt_reg      <= '0;
            ent_reg      <= 1'b0;
            status_reg   <= rgmt_pkg::ST_OK;
            gidx_reg     <= '0;
            gchk_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            removed_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            schk_vld_reg <= s_issue;
            if (cmd.load)
            begin
                sidx_reg    <= '0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
                status_reg  <= rgmt_pkg::ST_OK;
                found_reg   <= 1'b0;
                removed_reg <= 1'b0;
            end
            else if (cmd.clr || s_issue)
            begin
                sidx_reg <= sidx_reg + SCW'(1);
            end

            if (cmd.scan && schk_vld_reg)
            begin
                if (rd_vld && (rd_rob == robot_reg))
                begin
                    hit_reg <= 1'b1;
                end
                if (!rd_vld)
                begin
                    free_reg <= 1'b1;
                end
            end

            if (cmd.pick)
            begin
                cnt_reg <= hit_reg ? hcnt_reg : '0;
                ent_reg <= pk_ent;
                if (!hit_reg && need_alloc && !free_reg)
                begin
                    status_reg <= rgmt_pkg::ST_TABLE_FULL;
                end
            end

            if (cmd.upd)
            begin
                cnt_reg <= upd_cnt;
                ent_reg <= upd_vld;
                if (do_app && app_full)
                begin
                    status_reg <= rgmt_pkg::ST_LIST_FULL;
                end
            end

            if (cmd.prep_srch)
            begin
                gidx_reg     <= '0;
                gchk_vld_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.prep_shift)
            begin
                gidx_reg     <= fidx_reg + CW'(1);
                gchk_vld_reg <= 1'b0;
                removed_reg  <= 1'b1;
            end
            else
            begin
                gchk_vld_reg <= g_issue;
                if (g_issue)
                begin
                    gidx_reg <= gidx_reg + CW'(1);
                end
                if (cmd.srch && gchk_vld_reg && (grp_rd_reg == group_reg))
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.clr_last   = (sidx_reg == NLAST);
        sts.scan_done  = hit_reg || ((sidx_reg == N_S) && !schk_vld_reg);
        sts.hit        = hit_reg;
        sts.pk_ent     = pk_ent;
        sts.srch_done  = found_reg || ((gidx_reg == cnt_reg) && !gchk_vld_reg);
        sts.found      = found_reg;
        sts.shift_done = (gidx_reg == cnt_reg) && !gchk_vld_reg;
        sts.upd_ent    = upd_vld;
        sts.out_free   = !out_vld_reg || rsp_ready;
        sts.req_type   = req_type_reg;
        sts.first      = first_reg;
        sts.empty      = empty_reg;
    end

    assign rsp_valid     = out_vld_reg;
    assign status        = out_status_reg;
    assign is_member     = out_member_reg;
    assign entry_present = out_present_reg;
    assign group_count   = out_count_reg;

endmodule

// ===== hw/rtl/rgmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rgmt_ctrl
// Sequencer: clearing pass, slot scan, list search, shift, update, result.
// ----------------------------------------------------------------------------
module rgmt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rgmt_pkg::dp_sts_t sts,
    output rgmt_pkg::dp_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_PICK  = 9'b000001000,
        S_SRCH1 = 9'b000010000,
        S_SHIFT = 9'b000100000,
        S_UPD   = 9'b001000000,
        S_SRCH2 = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick = 1'b1;
                if (!sts.pk_ent)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (sts.req_type)
                        rgmt_pkg::REQ_JOIN:
                        begin
                            if (sts.hit)
                            begin
                                cmd.prep_srch = 1'b1;
                                state_next    = S_SRCH1;
                            end
                            else
                            begin
                                state_next = S_UPD;
                            end
                        end
                        rgmt_pkg::REQ_LEAVE:
                        begin
                            cmd.prep_srch = 1'b1;
                            state_next    = S_SRCH1;
                        end
                        rgmt_pkg::REQ_QUERY:
                        begin
                            cmd.prep_srch = 1'b1;
                            state_next    = S_SRCH2;
                        end
                        rgmt_pkg::REQ_REFRESH:
                        begin
                            if (!sts.first && sts.empty)
                            begin
                                cmd.prep_srch = 1'b1;
                                state_next    = S_SRCH2;
                            end
                            else
                            begin
                                state_next = S_UPD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH1:
            begin
                cmd.srch = 1'b1;
                if (sts.srch_done)
                begin
                    priority if (sts.req_type == rgmt_pkg::REQ_LEAVE && sts.found)
                    begin
                        cmd.prep_shift = 1'b1;
                        state_next     = S_SHIFT;
                    end
                    else if (sts.req_type == rgmt_pkg::REQ_JOIN && sts.found)
                    begin
                        cmd.prep_srch = 1'b1;
                        state_next    = S_SRCH2;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (sts.upd_ent)
                begin
                    cmd.prep_srch = 1'b1;
                    state_next    = S_SRCH2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SRCH2:
            begin
                cmd.srch = 1'b1;
                if (sts.srch_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rgmt_checker.sv =====
// ----------------------------------------------------------------------------
// rgmt_checker
// Port-level checks of the membership table, bound to the top level.
// ----------------------------------------------------------------------------
module rgmt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic       rsp_is_member,
    input logic       rsp_entry_present,
    input logic [3:0] rsp_group_count
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
            $stable({rsp_status, rsp_is_member, rsp_entry_present, rsp_group_count}))
        else $error("rsp payload changed while stalled");

    // one request in flight
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_entry_present |-> !rsp_is_member && rsp_group_count == 4'd0)
        else $error("membership reported without entry");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == rgmt_pkg::ST_OK ||
                       rsp_status == rgmt_pkg::ST_LIST_FULL ||
                       (rsp_status == rgmt_pkg::ST_TABLE_FULL && !rsp_entry_present)))
        else $error("bad status");

endmodule

bind robot_group_membership_table rgmt_checker u_rgmt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_is_member     (rsp.is_member),
    .rsp_entry_present (rsp.entry_present),
    .rsp_group_count   (rsp.group_count)
);
